FILE: design/mcrb_pkg.sv
// Shared types and constants of the multi-channel ring buffer core.
package mcrb_pkg;

    // Operation codes carried by the op field.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Fixed geometry: four up rings and four down rings.
    localparam int RING_COUNT = 8;
    localparam int RING_IDX_W = 3;
    localparam int LEN_W      = 9;
    localparam int POS_W      = 8;
    localparam int DATA_W     = 8;
    localparam int CNT_W      = 8;
    localparam int RUN_W      = 16;
    localparam int LEN_CAP    = 256;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // Access request from the ring control to the byte store.
    typedef struct packed {
        logic wr;
        logic rd;
    } mem_cmd_t;

    // Registered result fields, aligned with the store's read data.
    typedef struct packed {
        logic              done;
        logic              get_ok;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  free_space;
        logic [RUN_W-1:0]  run_count;
    } result_t;

endpackage

FILE: design/mcrb_byte_ram.sv
// Single-port byte store holding the contents of every ring.
module mcrb_byte_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                          clk,
    input  mcrb_pkg::mem_cmd_t            cmd,
    input  logic [ADDR_W-1:0]             addr,
    input  logic [mcrb_pkg::DATA_W-1:0]   wdata,
    output logic [mcrb_pkg::DATA_W-1:0]   rdata
);

    logic [mcrb_pkg::DATA_W-1:0] mem [DEPTH];
    logic [mcrb_pkg::DATA_W-1:0] rdata_reg;

    // Write on a put, registered read on a get.
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mcrb_ring_ctrl.sv
// Ring lengths, read and write positions, run counter and per-item decision.
module mcrb_ring_ctrl #(
    parameter int RING_DEPTH             = 256,
    parameter int CHANNELS_PER_DIRECTION = 4,
    parameter int ADDR_W                 = 11
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Item transaction
    input  logic                                  accept,
    input  logic [1:0]                            op,
    input  logic                                  direction,
    input  logic [1:0]                            channel,
    input  logic                                  last,
    // Configuration transaction
    input  logic                                  cfg_we,
    input  logic [mcrb_pkg::RING_IDX_W-1:0]       cfg_index,
    input  logic [mcrb_pkg::LEN_W-1:0]            cfg_data,
    // Store access
    output mcrb_pkg::mem_cmd_t                    mem_cmd,
    output logic [ADDR_W-1:0]                     mem_addr,
    // Result, in the cycle after the item
    output logic                                  res_valid,
    output mcrb_pkg::result_t                     res
);

    localparam int SLOT_W    = (2 * CHANNELS_PER_DIRECTION > 1) ?
                               $clog2(2 * CHANNELS_PER_DIRECTION) : 1;
    localparam int LEN_LIMIT = (RING_DEPTH < mcrb_pkg::LEN_CAP) ? RING_DEPTH : mcrb_pkg::LEN_CAP;

    logic [mcrb_pkg::LEN_W-1:0] len_reg    [mcrb_pkg::RING_COUNT];
    logic [mcrb_pkg::POS_W-1:0] wr_pos_reg [mcrb_pkg::RING_COUNT];
    logic [mcrb_pkg::POS_W-1:0] rd_pos_reg [mcrb_pkg::RING_COUNT];
    logic [mcrb_pkg::RUN_W-1:0] run_reg;
    logic [mcrb_pkg::RUN_W-1:0] run_next;
    logic                       res_valid_reg;
    mcrb_pkg::result_t          res_reg;
    mcrb_pkg::result_t          res_next;

    logic [mcrb_pkg::RING_IDX_W-1:0] sel;
    logic                            chan_ok;
    logic [SLOT_W-1:0]               slot;
    logic [mcrb_pkg::LEN_W-1:0]      sel_len;
    logic [mcrb_pkg::POS_W-1:0]      wp;
    logic [mcrb_pkg::POS_W-1:0]      rp;
    logic [mcrb_pkg::LEN_W-1:0]      used_now;
    logic [mcrb_pkg::LEN_W-1:0]      space_now;
    logic [mcrb_pkg::LEN_W-1:0]      used_after;
    logic [mcrb_pkg::LEN_W-1:0]      space_after;
    logic [mcrb_pkg::LEN_W-1:0]      wp_inc;
    logic [mcrb_pkg::LEN_W-1:0]      rp_inc;
    logic [mcrb_pkg::POS_W-1:0]      wp_wrap;
    logic [mcrb_pkg::POS_W-1:0]      rp_wrap;
    logic                            put_ok;
    logic                            get_ok;
    logic                            moved;
    logic [mcrb_pkg::LEN_W-1:0]      cfg_len;

    // Select the ring; a channel beyond the configured count acts as unallocated.
    assign sel     = {direction, channel};
    assign chan_ok = (32'(channel) < CHANNELS_PER_DIRECTION);
    assign sel_len = chan_ok ? len_reg[sel] : '0;
    assign slot    = direction ? SLOT_W'(CHANNELS_PER_DIRECTION + 32'(channel))
                               : SLOT_W'(channel);
    assign wp      = wr_pos_reg[sel];
    assign rp      = rd_pos_reg[sel];

    // Fill level before the item.
    always_comb
    begin
        if (sel_len == '0)
        begin
            used_now  = '0;
            space_now = '0;
        end
        else
        begin
            if (wp >= rp)
            begin
                used_now = {1'b0, wp} - {1'b0, rp};
            end
            else
            begin
                used_now = {1'b0, wp} + sel_len - {1'b0, rp};
            end
            space_now = sel_len - 9'd1 - used_now;
        end
    end

    // Decide whether the byte moves; op 3 behaves as a query.
    always_comb
    begin
        put_ok = 1'b0;
        get_ok = 1'b0;
        unique case (op)
            mcrb_pkg::OP_PUT: put_ok = accept && (space_now != '0);
            mcrb_pkg::OP_GET: get_ok = accept && (used_now != '0);
            default:          ;
        endcase
    end

    assign moved = put_ok || get_ok;

    // Positions advance by one and wrap at the ring length.
    assign wp_inc  = {1'b0, wp} + 9'd1;
    assign rp_inc  = {1'b0, rp} + 9'd1;
    assign wp_wrap = (wp_inc >= sel_len) ? '0 : wp_inc[mcrb_pkg::POS_W-1:0];
    assign rp_wrap = (rp_inc >= sel_len) ? '0 : rp_inc[mcrb_pkg::POS_W-1:0];

    // Fill level after the item.
    assign used_after  = used_now + 9'(put_ok) - 9'(get_ok);
    assign space_after = space_now - 9'(put_ok) + 9'(get_ok);

    // Run counter saturates and clears after the final item of a run.
    always_comb
    begin
        res_next.run_count = run_reg;
        if (moved && (run_reg != mcrb_pkg::RUN_MAX))
        begin
            res_next.run_count = run_reg + 16'd1;
        end
        run_next = run_reg;
        if (accept)
        begin
            run_next = last ? '0 : res_next.run_count;
        end
        res_next.done       = moved;
        res_next.get_ok     = get_ok;
        res_next.used       = used_after[mcrb_pkg::CNT_W-1:0];
        res_next.free_space = space_after[mcrb_pkg::CNT_W-1:0];
    end

    // Store access at the current position of the selected ring.
    assign mem_cmd.wr = put_ok;
    assign mem_cmd.rd = get_ok;
    assign mem_addr   = ADDR_W'(slot) * ADDR_W'(RING_DEPTH) + ADDR_W'(put_ok ? wp : rp);

    // Configured length is held to the ring size.
    assign cfg_len = (32'(cfg_data) > LEN_LIMIT) ? mcrb_pkg::LEN_W'(LEN_LIMIT) : cfg_data;

    // Lengths and positions; a length write also empties that ring.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcrb_pkg::RING_COUNT; i++)
            begin
                len_reg[i]    <= '0;
                wr_pos_reg[i] <= '0;
                rd_pos_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg[cfg_index]    <= cfg_len;
                wr_pos_reg[cfg_index] <= '0;
                rd_pos_reg[cfg_index] <= '0;
            end
            else
            begin
                if (put_ok)
                begin
                    wr_pos_reg[sel] <= wp_wrap;
                end
                if (get_ok)
                begin
                    rd_pos_reg[sel] <= rp_wrap;
                end
            end
        end
    end

    // Control registers: run counter and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            res_valid_reg <= accept;
        end
    end

    // Result payload, aligned with the store's read data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The store never sees a read and a write in one cycle.
    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_cmd.wr && mem_cmd.rd))
        else $error("store written and read in the same cycle");

    // Every accepted item gives a result in the following cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid)
        else $error("accepted item produced no result");

    // A byte that moved is counted in the reported run.
    a_done_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.done) |-> (res.run_count != '0))
        else $error("moved byte missing from run count");

    // Positions of an allocated ring stay below its length.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (sel_len != '0)) |-> ((9'(wp) < sel_len) && (9'(rp) < sel_len)))
        else $error("ring position beyond ring length");

endmodule

FILE: design/multi_channel_ring_buffer_core.sv
// Top level of the multi-channel ring buffer core: eight byte rings in one store.
//
//  Channel  Ports                                                         Handshake
//  item     start/busy; op, direction, channel, data_in, last             start && !busy
//  result   result_valid; done_res, data_out, used, free_space, run_count one-cycle strobe
//  config   cfg_valid/cfg_ready; cfg_index, cfg_data                      valid && ready
//
// An item is taken every cycle; busy stays low and cfg_ready stays high.
// Its result appears on the cycle after acceptance, aligned with the registered
// read data of the byte store, which is read or written at most once per item.
// Reset (rst_n low, asynchronous) sets all lengths, positions and the run
// counter to zero, so every ring is unallocated; the store needs no clearing.
// The receiver cannot stall, so results are never held back.
module multi_channel_ring_buffer_core #(
    parameter int RING_DEPTH             = 256,
    parameter int CHANNELS_PER_DIRECTION = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Item transaction
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          op,
    input  logic                                direction,
    input  logic [1:0]                          channel,
    input  logic [mcrb_pkg::DATA_W-1:0]         data_in,
    input  logic                                last,
    // Result transaction
    output logic                                result_valid,
    output logic                                done_res,
    output logic [mcrb_pkg::DATA_W-1:0]         data_out,
    output logic [mcrb_pkg::CNT_W-1:0]          used,
    output logic [mcrb_pkg::CNT_W-1:0]          free_space,
    output logic [mcrb_pkg::RUN_W-1:0]          run_count,
    // Configuration transaction
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcrb_pkg::RING_IDX_W-1:0]     cfg_index,
    input  logic [mcrb_pkg::LEN_W-1:0]          cfg_data
);

    localparam int STORE_DEPTH = 2 * CHANNELS_PER_DIRECTION * RING_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic                         accept;
    mcrb_pkg::mem_cmd_t           mem_cmd;
    logic [ADDR_W-1:0]            mem_addr;
    logic [mcrb_pkg::DATA_W-1:0]  mem_rdata;
    mcrb_pkg::result_t            res;

    // Both ports are always able to take a transaction.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    mcrb_ring_ctrl #(
        .RING_DEPTH             (RING_DEPTH),
        .CHANNELS_PER_DIRECTION (CHANNELS_PER_DIRECTION),
        .ADDR_W                 (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .direction (direction),
        .channel   (channel),
        .last      (last),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .res_valid (result_valid),
        .res       (res)
    );

    mcrb_byte_ram #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (data_in),
        .rdata (mem_rdata)
    );

    // Result fields; the fetched byte shows only for a successful get.
    assign done_res   = res.done;
    assign data_out   = res.get_ok ? mem_rdata : '0;
    assign used       = res.used;
    assign free_space = res.free_space;
    assign run_count  = res.run_count;

endmodule
